// ===== hw/rtl/scaled_glyph_box_emitter_defines.svh =====
// ============================================================================
// Assertion macros for the glyph box emitter
// Shared checking helpers, clocked on aclk and held off while aresetn is low.
// ============================================================================
`ifndef SCALED_GLYPH_BOX_EMITTER_DEFINES_SVH
`define SCALED_GLYPH_BOX_EMITTER_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define SGBE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define SGBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sgbe_pkg.sv =====
// ============================================================================
// Glyph box emitter package
// Font geometry, glyph numbering, character decode and the 5x7 font contents.
// ============================================================================
`default_nettype none

package sgbe_pkg;

    // Font geometry.
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
    localparam int GLYPH_COUNT = 42;
    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
    localparam int COL_CNT_W   = $clog2(GLYPH_COLS);

    // Field widths.
    localparam int CODE_W   = 8;
    localparam int ORIGIN_W = 9;
    localparam int COORD_W  = 10;
    localparam int COLOR_W  = 16;
    localparam int SCALE_W  = 4;
    localparam int STEP_W   = 3;

    // Channel widths.
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 56;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SCALE = 8'd1;

    // Scale limits.
    localparam logic [SCALE_W-1:0] SCALE_MIN = 4'd1;
    localparam logic [SCALE_W-1:0] SCALE_MAX = 4'd8;

    // Character codes that bound the decoded ranges.
    localparam logic [CODE_W-1:0] ASCII_DIGIT0 = 8'h30;
    localparam logic [CODE_W-1:0] ASCII_DIGIT9 = 8'h39;
    localparam logic [CODE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CODE_W-1:0] ASCII_UPPER_I = 8'h49;
    localparam logic [CODE_W-1:0] ASCII_UPPER_K = 8'h4B;
    localparam logic [CODE_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CODE_W-1:0] ASCII_DASH   = 8'h2D;
    localparam logic [CODE_W-1:0] ASCII_PLUS   = 8'h2B;
    localparam logic [CODE_W-1:0] ASCII_EQUAL  = 8'h3D;
    localparam logic [CODE_W-1:0] ASCII_SLASH  = 8'h2F;
    localparam logic [CODE_W-1:0] ASCII_AMP    = 8'h26;
    localparam logic [CODE_W-1:0] ASCII_COLON  = 8'h3A;

    // Glyph numbers in the font memory.
    localparam logic [GLYPH_IDX_W-1:0] GI_BLANK  = 6'd0;
    localparam logic [GLYPH_IDX_W-1:0] GI_DASH   = 6'd1;
    localparam logic [GLYPH_IDX_W-1:0] GI_PLUS   = 6'd2;
    localparam logic [GLYPH_IDX_W-1:0] GI_EQUAL  = 6'd3;
    localparam logic [GLYPH_IDX_W-1:0] GI_SLASH  = 6'd4;
    localparam logic [GLYPH_IDX_W-1:0] GI_AMP    = 6'd5;
    localparam logic [GLYPH_IDX_W-1:0] GI_COLON  = 6'd6;
    localparam logic [GLYPH_IDX_W-1:0] GI_DIGIT0 = 6'd7;
    localparam logic [GLYPH_IDX_W-1:0] GI_UPPER_A = 6'd17;
    localparam logic [GLYPH_IDX_W-1:0] GI_UPPER_K = 6'd26;

    // One glyph in scan order: bit k is row k/5, column k%5 from the left.
    typedef logic [GLYPH_BITS-1:0]  glyph_bits_t;
    typedef logic [GLYPH_IDX_W-1:0] glyph_idx_t;
    typedef logic [COORD_W-1:0]     coord_t;
    typedef logic [GLYPH_COLS-1:0]  font_row_t;

    // Maps a character code to its glyph number; unknown codes get the blank.
    function automatic glyph_idx_t glyph_index(input logic [CODE_W-1:0] code);
        glyph_idx_t idx;
        priority if (code >= ASCII_DIGIT0 && code <= ASCII_DIGIT9) begin
            idx = GI_DIGIT0 + GLYPH_IDX_W'(code - ASCII_DIGIT0);
        end else if (code >= ASCII_UPPER_A && code <= ASCII_UPPER_I) begin
            idx = GI_UPPER_A + GLYPH_IDX_W'(code - ASCII_UPPER_A);
        end else if (code >= ASCII_UPPER_K && code <= ASCII_UPPER_Z) begin
            idx = GI_UPPER_K + GLYPH_IDX_W'(code - ASCII_UPPER_K);
        end else if (code == ASCII_DASH) begin
            idx = GI_DASH;
        end else if (code == ASCII_PLUS) begin
            idx = GI_PLUS;
        end else if (code == ASCII_EQUAL) begin
            idx = GI_EQUAL;
        end else if (code == ASCII_SLASH) begin
            idx = GI_SLASH;
        end else if (code == ASCII_AMP) begin
            idx = GI_AMP;
        end else if (code == ASCII_COLON) begin
            idx = GI_COLON;
        end else begin
            idx = GI_BLANK;
        end
        return idx;
    endfunction

    // Packs seven font rows (bit 4 leftmost) into scan order.
    function automatic glyph_bits_t make_glyph(
        input font_row_t r0, input font_row_t r1, input font_row_t r2,
        input font_row_t r3, input font_row_t r4, input font_row_t r5,
        input font_row_t r6
    );
        font_row_t   rows [GLYPH_ROWS];
        glyph_bits_t g;
        rows[0] = r0; rows[1] = r1; rows[2] = r2; rows[3] = r3;
        rows[4] = r4; rows[5] = r5; rows[6] = r6;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            for (int c = 0; c < GLYPH_COLS; c++) begin
                g[r * GLYPH_COLS + c] = rows[r][GLYPH_COLS - 1 - c];
            end
        end
        return g;
    endfunction

    // Font contents by glyph number.
    function automatic glyph_bits_t font_glyph(input glyph_idx_t idx);
        glyph_bits_t g;
        unique case (idx)
            6'd1:  g = make_glyph(5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0);
            6'd2:  g = make_glyph(5'd0,  5'd4,  5'd4,  5'd31, 5'd4,  5'd4,  5'd0);
            6'd3:  g = make_glyph(5'd0,  5'd31, 5'd0,  5'd31, 5'd0,  5'd0,  5'd0);
            6'd4:  g = make_glyph(5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd0,  5'd0);
            6'd5:  g = make_glyph(5'd12, 5'd18, 5'd20, 5'd8,  5'd21, 5'd18, 5'd13);
            6'd6:  g = make_glyph(5'd0,  5'd4,  5'd0,  5'd0,  5'd4,  5'd0,  5'd0);
            6'd7:  g = make_glyph(5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14);
            6'd8:  g = make_glyph(5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14);
            6'd9:  g = make_glyph(5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31);
            6'd10: g = make_glyph(5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30);
            6'd11: g = make_glyph(5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2);
            6'd12: g = make_glyph(5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30);
            6'd13: g = make_glyph(5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14);
            6'd14: g = make_glyph(5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8);
            6'd15: g = make_glyph(5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14);
            6'd16: g = make_glyph(5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14);
            6'd17: g = make_glyph(5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17);
            6'd18: g = make_glyph(5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30);
            6'd19: g = make_glyph(5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14);
            6'd20: g = make_glyph(5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30);
            6'd21: g = make_glyph(5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31);
            6'd22: g = make_glyph(5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16);
            6'd23: g = make_glyph(5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14);
            6'd24: g = make_glyph(5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17);
            6'd25: g = make_glyph(5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14);
            6'd26: g = make_glyph(5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17);
            6'd27: g = make_glyph(5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31);
            6'd28: g = make_glyph(5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17);
            6'd29: g = make_glyph(5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17);
            6'd30: g = make_glyph(5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14);
            6'd31: g = make_glyph(5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16);
            6'd32: g = make_glyph(5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13);
            6'd33: g = make_glyph(5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17);
            6'd34: g = make_glyph(5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30);
            6'd35: g = make_glyph(5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4);
            6'd36: g = make_glyph(5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14);
            6'd37: g = make_glyph(5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4);
            6'd38: g = make_glyph(5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10);
            6'd39: g = make_glyph(5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd10, 5'd17);
            6'd40: g = make_glyph(5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4);
            6'd41: g = make_glyph(5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31);
            // The blank glyph and numbers beyond the font.
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sgbe_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ============================================================================
`default_nettype none

module sgbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/scaled_glyph_box_emitter.sv =====
// ============================================================================
// Scaled glyph box emitter
// Turns one character draw request into filled boxes, one per set pixel of
// its 5x7 glyph, each box scaled by glyph_scale and painted in text_color.
// ============================================================================
//
//  Channel  Direction  Handshake            Contents
//  s_       in         s_tvalid/s_tready    origin and character code
//  m_       out        m_tvalid/m_tready    box corners and color, tlast = last box
//  cfg_     in         cfg_valid/cfg_ready  register index and write data
//
//  After reset the font memory is loaded; requests wait until then.
//  A request is accepted while idle, its glyph is read from font memory, and the
//  scan runs over the pixels up to the last set one; a blank glyph skips it.
//  The pixel scan advances only when the output register is free or taken.
//  A new request is accepted once the scan has ended, even if the last box waits.
//
`default_nettype none
`include "scaled_glyph_box_emitter_defines.svh"

module scaled_glyph_box_emitter (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Request: origin_col [8:0], origin_row [17:9], char_code [25:18].
    input  wire logic [sgbe_pkg::S_DATA_W-1:0]     s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Box: box_left [9:0], box_top [19:10], box_right [29:20],
    // box_bottom [39:30], box_color [55:40].
    output logic      [sgbe_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Configuration writes.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sgbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sgbe_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import sgbe_pkg::*;

    localparam logic [1:0] ST_FILL = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_SCAN = 2'd3;

    logic [1:0]            state_reg, state_next;
    glyph_idx_t            fill_idx_reg, fill_idx_next;
    logic [COLOR_W-1:0]    text_color_reg;
    logic [SCALE_W-1:0]    glyph_scale_reg;
    glyph_bits_t           glyph_reg, glyph_next;
    logic [COL_CNT_W-1:0]  col_reg, col_next;
    coord_t                origin_col_reg, origin_col_next;
    coord_t                left_reg, left_next;
    coord_t                top_reg, top_next;
    logic [STEP_W:0]       step_reg, step_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_last_reg, m_last_next;
    coord_t                box_left_reg, box_left_next;
    coord_t                box_top_reg, box_top_next;
    coord_t                box_right_reg, box_right_next;
    coord_t                box_bottom_reg, box_bottom_next;
    logic [COLOR_W-1:0]    box_color_reg, box_color_next;

    logic                  in_accept;
    logic                  advance;
    logic                  ram_wr_en;
    glyph_idx_t            ram_rd_addr;
    glyph_bits_t           ram_rd_data;
    logic [SCALE_W-1:0]    scale_eff;
    glyph_bits_t           glyph_shifted;
    coord_t                extent;

    // Font memory, loaded from the package contents after reset.
    sgbe_ram #(
        .WIDTH (GLYPH_BITS),
        .DEPTH (GLYPH_COUNT)
    ) u_font_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (fill_idx_reg),
        .wr_data (font_glyph(fill_idx_reg)),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign ram_wr_en   = (state_reg == ST_FILL);
    assign ram_rd_addr = glyph_index(s_tdata[2*ORIGIN_W +: CODE_W]);

    // Handshakes.
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign advance   = (state_reg == ST_SCAN) && (!m_valid_reg || m_tready);

    // Scale held to the range 1..8.
    always_comb begin
        priority if (glyph_scale_reg < SCALE_MIN) begin
            scale_eff = SCALE_MIN;
        end else if (glyph_scale_reg > SCALE_MAX) begin
            scale_eff = SCALE_MAX;
        end else begin
            scale_eff = glyph_scale_reg;
        end
    end

    assign glyph_shifted = glyph_reg >> 1;
    assign extent        = COORD_W'(step_reg) - COORD_W'(1);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg  <= '1;
            glyph_scale_reg <= SCALE_MIN;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_TEXT_COLOR) begin
                text_color_reg <= cfg_data[COLOR_W-1:0];
            end else if (cfg_index == CFG_GLYPH_SCALE) begin
                glyph_scale_reg <= cfg_data[SCALE_W-1:0];
            end
        end
    end

    // Sequencer: font load, memory read, pixel scan.
    always_comb begin
        state_next      = state_reg;
        fill_idx_next   = fill_idx_reg;
        glyph_next      = glyph_reg;
        col_next        = col_reg;
        origin_col_next = origin_col_reg;
        left_next       = left_reg;
        top_next        = top_reg;
        step_next       = step_reg;
        m_valid_next    = m_valid_reg;
        m_last_next     = m_last_reg;
        box_left_next   = box_left_reg;
        box_top_next    = box_top_reg;
        box_right_next  = box_right_reg;
        box_bottom_next = box_bottom_reg;
        box_color_next  = box_color_reg;

        // The output register empties when its box is taken.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_FILL: begin
                fill_idx_next = fill_idx_reg + GLYPH_IDX_W'(1);
                if (fill_idx_reg == GLYPH_IDX_W'(GLYPH_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    origin_col_next = COORD_W'(s_tdata[ORIGIN_W-1:0]);
                    left_next       = COORD_W'(s_tdata[ORIGIN_W-1:0]);
                    top_next        = COORD_W'(s_tdata[ORIGIN_W +: ORIGIN_W]);
                    step_next       = (STEP_W + 1)'(scale_eff);
                    col_next        = '0;
                    state_next      = ST_READ;
                end
            end
            ST_READ: begin
                glyph_next = ram_rd_data;
                state_next = (ram_rd_data == '0) ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN: begin
                if (advance) begin
                    // A set pixel loads one box into the output register.
                    if (glyph_reg[0]) begin
                        m_valid_next    = 1'b1;
                        m_last_next     = (glyph_shifted == '0);
                        box_left_next   = left_reg;
                        box_top_next    = top_reg;
                        box_right_next  = left_reg + extent;
                        box_bottom_next = top_reg + extent;
                        box_color_next  = text_color_reg;
                    end
                    // Step to the next pixel position.
                    glyph_next = glyph_shifted;
                    if (col_reg == COL_CNT_W'(GLYPH_COLS - 1)) begin
                        col_next  = '0;
                        left_next = origin_col_reg;
                        top_next  = top_reg + COORD_W'(step_reg);
                    end else begin
                        col_next  = col_reg + COL_CNT_W'(1);
                        left_next = left_reg + COORD_W'(step_reg);
                    end
                    if (glyph_shifted == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            fill_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_idx_reg <= fill_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Scan and output payload registers.
    always_ff @(posedge aclk) begin
        glyph_reg      <= glyph_next;
        col_reg        <= col_next;
        origin_col_reg <= origin_col_next;
        left_reg       <= left_next;
        top_reg        <= top_next;
        step_reg       <= step_next;
        m_last_reg     <= m_last_next;
        box_left_reg   <= box_left_next;
        box_top_reg    <= box_top_next;
        box_right_reg  <= box_right_next;
        box_bottom_reg <= box_bottom_next;
        box_color_reg  <= box_color_next;
    end

    // Output channel.
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {box_color_reg, box_bottom_reg, box_right_reg,
                       box_top_reg, box_left_reg};

    // Checks.
    `SGBE_ASSERT_NOW(a_no_box_during_fill, state_reg == ST_FILL, !m_valid_reg,
        "box emitted while the font memory was loading")
    `SGBE_ASSERT_NEXT(a_accept_reads_font, in_accept, state_reg == ST_READ,
        "accepted request did not start a font read")
    `SGBE_ASSERT_NOW(a_scan_has_pixels, state_reg == ST_SCAN, glyph_reg != '0,
        "scan running with no pixels left")
    `SGBE_ASSERT_NEXT(a_set_pixel_emits, advance && glyph_reg[0], m_valid_reg,
        "set pixel did not load a box")
    `SGBE_ASSERT_NEXT(a_last_ends_scan, advance && glyph_reg[0] && glyph_shifted == '0,
        m_last_reg && state_reg == ST_IDLE,
        "final box not flagged or scan not ended")

endmodule

`default_nettype wire
